@@ sv/bdlp_pkg.sv @@
// ---------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debouncer with long-press
// detection.
// ---------------------------------------------------------------------------
package bdlp_pkg;

    // Sizes fixed by the field definitions
    localparam int NUM_BUTTONS_DEF = 20;
    localparam int RAW_W           = 20;
    localparam int HIST_W          = 3;
    localparam int CNT_W           = 16;
    localparam int DIV_W           = 8;
    localparam int IDX_OUT_W       = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int ENTRY_W         = HIST_W + CNT_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;

    // Reset values
    localparam logic [DIV_W-1:0] TICK_DIV_RST = 8'd5;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd200;

    // History patterns
    localparam logic [HIST_W-1:0] HIST_ALL_REL = 3'b111;
    localparam logic [HIST_W-1:0] HIST_PRESS   = 3'b100;
    localparam logic [HIST_W-1:0] HIST_RELEASE = 3'b011;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        t_kind                kind;
        logic                 last;
    } t_event;

    typedef struct packed {
        logic   vld;
        t_event ev;
    } t_push;

    typedef struct packed {
        logic [HIST_W-1:0] hist;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

endpackage

@@ sv/bdlp_ram.sv @@
// ---------------------------------------------------------------------------
// bdlp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bdlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/bdlp_out.sv @@
// ---------------------------------------------------------------------------
// bdlp_out
// Output register for event items; frees itself when the item is taken.
// ---------------------------------------------------------------------------
module bdlp_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdlp_pkg::t_push i_push,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output bdlp_pkg::t_event o_event
);
    import bdlp_pkg::*;

    logic   r_vld;
    t_event r_ev;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_event = r_ev;

    // Hold the item until taken, load a new one when pushed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push.vld) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_ev <= i_push.ev;
        end
    end

endmodule

@@ sv/bdlp_scan.sv @@
// ---------------------------------------------------------------------------
// bdlp_scan
// Walks the per-button state memory once per sample: read, update the
// history and long-press counter, write back, and queue events.
// ---------------------------------------------------------------------------
module bdlp_scan #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bdlp_pkg::RAW_W-1:0] i_raw,
    input  logic [bdlp_pkg::CNT_W-1:0] i_long_samples,
    output logic                       o_idle,
    output bdlp_pkg::t_push            o_push,
    input  logic                       i_out_free
);
    import bdlp_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    t_state             r_state, n_state;
    logic [RAW_W-1:0]   r_raw;
    logic [IDX_W-1:0]   r_issue_idx;
    logic               r_issue_more;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_rd_ent_vld;
    logic               r_ent_vld [NUM_BUTTONS];
    logic               r_pend_vld;
    t_event             r_pend_ev;

    logic [ENTRY_W-1:0] w_rdata;
    t_entry             w_cur;
    t_entry             w_upd;
    logic [31:0]        w_raw_ext;
    logic               w_bit;
    logic [HIST_W-1:0]  w_hist;
    logic               w_hit;
    t_kind              w_kind;
    logic               w_stall;
    logic               w_advance;
    logic               w_we;
    logic               w_final;
    logic [IDX_W-1:0]   w_raddr;

    bdlp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUTTONS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cmp_idx),
        .i_wdata(w_upd),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Unwritten entries read as all released with an idle counter
    assign w_cur     = r_rd_ent_vld ? t_entry'(w_rdata)
                                    : t_entry'{hist: HIST_ALL_REL, cnt: '0};
    assign w_raw_ext = {{(32 - RAW_W){1'b0}}, r_raw};
    assign w_bit     = w_raw_ext[5'(r_cmp_idx)];
    assign w_hist    = {w_cur.hist[HIST_W-2:0], w_bit};

    // Classify the new history and update the counter
    always_comb begin
        w_hit       = 1'b0;
        w_kind      = EV_PRESS;
        w_upd.hist  = w_hist;
        w_upd.cnt   = w_cur.cnt;
        if (w_hist == HIST_PRESS) begin
            w_hit     = 1'b1;
            w_kind    = EV_PRESS;
            w_upd.cnt = i_long_samples;
        end else if (w_hist == HIST_RELEASE) begin
            w_hit     = 1'b1;
            w_kind    = EV_RELEASE;
            w_upd.cnt = '0;
        end else if (w_cur.cnt != '0) begin
            w_upd.cnt = w_cur.cnt - 1'b1;
            if (w_cur.cnt == CNT_W'(1)) begin
                w_hit  = 1'b1;
                w_kind = EV_LONG;
            end
        end
    end

    // Stall when a new event meets a held one and the output is busy
    assign w_stall   = r_cmp_vld && w_hit && r_pend_vld && !i_out_free;
    assign w_advance = (r_state == S_SCAN) && !w_stall;
    assign w_we      = r_cmp_vld && w_advance;
    assign w_final   = r_cmp_vld && !r_issue_more && w_advance;
    assign w_raddr   = w_stall ? r_cmp_idx : r_issue_idx;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SCAN;
            S_SCAN:  if (w_final) n_state = S_FLUSH;
            S_FLUSH: if (!r_pend_vld || i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: push the held event when a newer one replaces it, or at the end
    always_comb begin
        o_idle        = 1'b0;
        o_push.vld    = 1'b0;
        o_push.ev     = r_pend_ev;
        o_push.ev.last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
            end
            S_SCAN: begin
                o_push.vld = w_we && w_hit && r_pend_vld;
            end
            S_FLUSH: begin
                o_push.vld     = r_pend_vld && i_out_free;
                o_push.ev.last = 1'b1;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the read and update pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_more <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_rd_ent_vld <= 1'b0;
        end else begin
            r_rd_ent_vld <= r_ent_vld[w_raddr];
            if (i_start && r_state == S_IDLE) begin
                r_issue_idx  <= '0;
                r_issue_more <= 1'b1;
                r_cmp_vld    <= 1'b0;
            end else if (w_advance) begin
                r_cmp_vld <= r_issue_more;
                r_cmp_idx <= r_issue_idx;
                if (r_issue_more && r_issue_idx != LAST_IDX) begin
                    r_issue_idx <= r_issue_idx + 1'b1;
                end else begin
                    r_issue_more <= 1'b0;
                end
            end else if (r_state != S_SCAN) begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == S_IDLE) begin
            r_raw <= i_raw;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_ent_vld[i] <= 1'b0;
            end
        end else if (w_we) begin
            r_ent_vld[r_cmp_idx] <= 1'b1;
        end
    end

    // Hold the most recent event until the next one or the end of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (w_we && w_hit) begin
            r_pend_vld <= 1'b1;
        end else if (r_state == S_FLUSH && i_out_free) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_hit) begin
            r_pend_ev.idx  <= IDX_OUT_W'(r_cmp_idx);
            r_pend_ev.kind <= w_kind;
            r_pend_ev.last <= 1'b0;
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_vld)
        else $error("event still held while idle");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_issue_more) |-> (w_raddr != r_cmp_idx))
        else $error("read and write hit the same entry");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> (r_cmp_vld && r_cmp_idx == $past(r_cmp_idx)))
        else $error("update stage moved during a stall");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.vld && r_state == S_SCAN) |-> (!o_push.ev.last && i_out_free))
        else $error("mid-scan push marked last or output busy");

endmodule

@@ sv/button_debounce_long_press_top.sv @@
// ---------------------------------------------------------------------------
// button_debounce_long_press_top
// Debouncer for a bank of buttons with press, release and long-press events.
// ---------------------------------------------------------------------------
// Ticks: a tick that takes no sample leaves the block ready for the next; a
//   sampling tick walks the state memory before the block takes another tick.
// Throughput: one tick at a time; set by the single read/write port pair
//   of the state memory, one button entry per cycle while no event stall holds it.
// Reset: clears control state and the per-entry valid bits; unwritten
//   entries read as released with an idle counter, so no clearing pass.
module button_debounce_long_press_top #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bdlp_pkg::RAW_W-1:0]      i_raw_buttons,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bdlp_pkg::IDX_OUT_W-1:0]  o_button_index,
    output logic [1:0]                      o_event_kind,
    output logic                            o_last_event,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bdlp_pkg::*;

    logic [DIV_W-1:0] r_tick_div;
    logic [CNT_W-1:0] r_long;
    logic [DIV_W-1:0] r_pre;
    logic [DIV_W-1:0] n_pre;
    logic             w_accept;
    logic             w_start;
    logic             w_idle;
    logic             w_free;
    t_push            w_push;
    t_event           w_ev;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_idle;
    assign w_accept    = i_valid && w_idle;
    assign n_pre       = r_pre - 1'b1;
    assign w_start     = w_accept && (n_pre == '0);

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div <= TICK_DIV_RST;
            r_long     <= LONG_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_DIVIDE: r_tick_div <= i_cfg_data[DIV_W-1:0];
                CFG_LONG_PRESS:  r_long     <= i_cfg_data[CNT_W-1:0];
                default:         r_long     <= r_long;
            endcase
        end
    end

    // Count ticks down, reload on the sampling tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= TICK_DIV_RST;
        end else if (w_accept) begin
            r_pre <= (n_pre == '0) ? r_tick_div : n_pre;
        end
    end

    bdlp_scan #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_raw         (i_raw_buttons),
        .i_long_samples(r_long),
        .o_idle        (w_idle),
        .o_push        (w_push),
        .i_out_free    (w_free)
    );

    bdlp_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_free (w_free),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_event(w_ev)
    );

    assign o_button_index = w_ev.idx;
    assign o_event_kind   = w_ev.kind;
    assign o_last_event   = w_ev.last;

endmodule

@@ tb/tb_button_debounce_long_press_top.sv @@
// ---------------------------------------------------------------------------
// tb_button_debounce_long_press_top
// Self-checking bench for the button debouncer with long-press detection.
// A directed plan walks reset behavior, all-button presses, releases and
// long presses, the highest button, a zero long-press count and ignored
// register indexes. Random phases then feed mostly clean button activity
// with glitches under several prescaler and long-press settings, a slower
// prescaler setting included. Every event is checked against a
// cycle-free model of the debouncer kept in the bench.
// ---------------------------------------------------------------------------
module tb_button_debounce_long_press_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdlp_pkg::*;

    localparam int NB         = NUM_BUTTONS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = NB + 4;
    localparam int SHOW_MAX   = 10;

    // Register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Random phases: prescaler, long-press count, sample ticks, no idling
    localparam int N_PHASES = 7;
    localparam int PH_DIV   [N_PHASES] = '{1, 1, 2, 3, 5, 1, 12};
    localparam int PH_LP    [N_PHASES] = '{1, 3, 6, 2, 1, 65535, 4};
    localparam int PH_SCANS [N_PHASES] = '{40, 30, 20, 12, 6, 15, 3};
    localparam int PH_QUIET [N_PHASES] = '{0, 1, 0, 0, 0, 0, 0};

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_row_chk;

    typedef struct {
        t_row_op              op;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [RAW_W-1:0]     val;
        t_row_chk             chk;
        t_event               ev;
    } t_plan_row;

    // DUT signals
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [RAW_W-1:0]      i_raw_buttons  = '1;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [IDX_OUT_W-1:0]  o_button_index;
    logic [1:0]            o_event_kind;
    logic                  o_last_event;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Debouncer model state
    logic [DIV_W-1:0]  mdl_div;
    logic [CNT_W-1:0]  mdl_lp;
    logic [DIV_W-1:0]  mdl_scan_cnt;
    logic [HIST_W-1:0] mdl_hist [NB];
    logic [CNT_W-1:0]  mdl_hold [NB];

    t_event            pending_events [$];
    t_plan_row         plan [$];
    logic [RAW_W-1:0]  btn_level = '1;

    bit quiet     = 1'b0;
    int rx_stall  = 0;
    int idle_cycles = 0;
    int n_err     = 0;
    int n_ticks   = 0;
    int n_scans   = 0;
    int n_events  = 0;
    int n_writes  = 0;

    button_debounce_long_press_top #(
        .NUM_BUTTONS (NB)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_raw_buttons  (i_raw_buttons),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_button_index (o_button_index),
        .o_event_kind   (o_event_kind),
        .o_last_event   (o_last_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bring the model to its reset state
    task automatic debounce_reset();
        mdl_div      = TICK_DIV_RST;
        mdl_lp       = LONG_RST;
        mdl_scan_cnt = TICK_DIV_RST;
        for (int b = 0; b < NB; b++) begin
            mdl_hist[b] = HIST_ALL_REL;
            mdl_hold[b] = '0;
        end
    endtask

    // Advance the model by one tick and queue the events it raises
    task automatic debounce_tick(input logic [RAW_W-1:0] raw);
        t_event            evs [$];
        t_event            ev;
        logic [HIST_W-1:0] h;
        n_ticks++;
        mdl_scan_cnt = mdl_scan_cnt - 1'b1;
        if (mdl_scan_cnt != '0)
            return;
        mdl_scan_cnt = mdl_div;
        n_scans++;
        for (int b = 0; b < NB; b++) begin
            h = {mdl_hist[b][HIST_W-2:0], raw[b]};
            mdl_hist[b] = h;
            ev.idx  = IDX_OUT_W'(b);
            ev.last = 1'b0;
            if (h == HIST_PRESS) begin
                ev.kind = EV_PRESS;
                evs.push_back(ev);
                mdl_hold[b] = mdl_lp;
            end else if (h == HIST_RELEASE) begin
                ev.kind = EV_RELEASE;
                evs.push_back(ev);
                mdl_hold[b] = '0;
            end else if (mdl_hold[b] != '0) begin
                mdl_hold[b] = mdl_hold[b] - 1'b1;
                if (mdl_hold[b] == '0) begin
                    ev.kind = EV_LONG;
                    evs.push_back(ev);
                end
            end
        end
        if (evs.size() > 0)
            evs[evs.size()-1].last = 1'b1;
        foreach (evs[k])
            pending_events.push_back(evs[k]);
    endtask

    // Random idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly clean button activity, with glitches and a little noise
    function automatic logic [RAW_W-1:0] next_sample();
        logic [RAW_W-1:0] raw;
        for (int b = 0; b < RAW_W; b++)
            if ($urandom_range(0, 9) == 0)
                btn_level[b] = ~btn_level[b];
        raw = btn_level;
        if ($urandom_range(0, 4) == 0)
            raw[$urandom_range(0, RAW_W-1)] ^= 1'b1;
        if ($urandom_range(0, 29) == 0)
            raw = RAW_W'($urandom);
        return raw;
    endfunction

    task automatic note_err(input string msg);
        n_err++;
        if (n_err <= SHOW_MAX)
            $display("ERROR: %s", msg);
    endtask

    // Send one tick and record what it should raise
    task automatic send_tick(input logic [RAW_W-1:0] raw, input t_row_chk chk,
                             input t_event ev);
        int gap;
        int depth;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_raw_buttons <= raw;
        do @(posedge i_clk); while (!o_ready);
        depth = pending_events.size();
        debounce_tick(raw);
        if (chk != CHK_MODEL) begin
            while (pending_events.size() > depth)
                void'(pending_events.pop_back());
            if (chk == CHK_ONE)
                pending_events.push_back(ev);
        end
    endtask

    // Write a register once every event is out and the block has settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        case (idx)
            CFG_TICK_DIVIDE: mdl_div = data[DIV_W-1:0];
            CFG_LONG_PRESS:  mdl_lp  = data;
            default: ;
        endcase
    endtask

    task automatic add_tick(input logic [RAW_W-1:0] raw, input t_row_chk chk,
                            input int idx = 0, input t_kind kind = EV_PRESS);
        t_plan_row row;
        row.op      = ROW_TICK;
        row.reg_idx = '0;
        row.val     = raw;
        row.chk     = chk;
        row.ev.idx  = IDX_OUT_W'(idx);
        row.ev.kind = kind;
        row.ev.last = 1'b1;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row.op      = ROW_CFG;
        row.reg_idx = idx;
        row.val     = RAW_W'(data);
        row.chk     = CHK_MODEL;
        row.ev      = '0;
        plan.push_back(row);
    endtask

    // Receiver pacing: random stalls, none while quiet
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check each event against the oldest expectation
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_valid && i_ready) begin
            n_events++;
            if (pending_events.size() == 0) begin
                note_err($sformatf("unexpected event: button %0d kind %0d last %0b",
                                   o_button_index, o_event_kind, o_last_event));
            end else begin
                want = pending_events.pop_front();
                if (o_button_index !== want.idx || o_event_kind !== want.kind ||
                    o_last_event !== want.last)
                    note_err($sformatf(
                        "event mismatch: exp button %0d kind %0d last %0b, got %0d %0d %0b",
                        want.idx, want.kind, want.last,
                        o_button_index, o_event_kind, o_last_event));
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_event no_ev;
        no_ev = '0;
        debounce_reset();

        // Directed plan
        for (int k = 0; k < 4; k++)
            add_tick(20'hFFFFF, CHK_NONE);          // prescaler still running
        add_tick(20'hFFFFF, CHK_NONE);              // first sample, all released
        add_cfg(CFG_TICK_DIVIDE, 16'd1);
        add_cfg(CFG_LONG_PRESS, 16'd2);
        for (int k = 0; k < 4; k++)
            add_tick(20'h00000, CHK_NONE);          // old count runs out first
        add_tick(20'h00000, CHK_NONE);              // history 110
        add_tick(20'h00000, CHK_MODEL);             // all buttons pressed
        add_tick(20'h00000, CHK_MODEL);
        add_tick(20'h00000, CHK_MODEL);             // all long presses
        add_tick(20'hFFFFF, CHK_MODEL);
        add_tick(20'hFFFFF, CHK_MODEL);             // all released
        add_tick(20'h7FFFF, CHK_MODEL);
        add_tick(20'h7FFFF, CHK_ONE, NB - 1, EV_PRESS);
        add_cfg(CFG_LONG_PRESS, 16'd0);
        add_tick(20'h7FFFF, CHK_MODEL);
        add_tick(20'h7FFFF, CHK_MODEL);             // long press of top button
        add_tick(20'hFFFFE, CHK_MODEL);
        add_tick(20'hFFFFE, CHK_MODEL);             // press with zero count
        add_tick(20'hFFFFE, CHK_MODEL);
        add_tick(20'hFFFFE, CHK_MODEL);
        add_cfg(CFG_SPARE_A, 16'hFFFF);
        add_cfg(CFG_SPARE_B, 16'h0000);
        add_tick(20'hFFFFF, CHK_MODEL);
        add_tick(20'hFFFFF, CHK_MODEL);             // release, prescaler untouched
        add_cfg(CFG_LONG_PRESS, 16'hFFFF);
        add_cfg(CFG_TICK_DIVIDE, 16'h00FF);

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed plan
        foreach (plan[r]) begin
            if (plan[r].op == ROW_CFG)
                write_reg(plan[r].reg_idx, plan[r].val[CFG_DATA_W-1:0]);
            else
                send_tick(plan[r].val, plan[r].chk, plan[r].ev);
        end

        // Random phases under several settings
        for (int p = 0; p < N_PHASES; p++) begin
            int scans_done;
            write_reg(CFG_TICK_DIVIDE, CFG_DATA_W'(PH_DIV[p]));
            write_reg(CFG_LONG_PRESS, CFG_DATA_W'(PH_LP[p]));
            quiet = PH_QUIET[p] != 0;
            scans_done = n_scans;
            while (n_scans - scans_done < PH_SCANS[p]) begin
                if (mdl_scan_cnt == DIV_W'(1))
                    send_tick(next_sample(), CHK_MODEL, no_ev);
                else
                    send_tick(RAW_W'($urandom), CHK_MODEL, no_ev);
            end
            quiet = 1'b0;
        end

        // Drain
        i_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);

        $display("Covered %0d ticks, %0d of them sampled, %0d events, %0d register writes",
                 n_ticks, n_scans, n_events, n_writes);
        $display("Mismatches found: %0d", n_err);
        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bdlp_pkg.sv
sv/bdlp_ram.sv
sv/bdlp_out.sv
sv/bdlp_scan.sv
sv/button_debounce_long_press_top.sv
tb/tb_button_debounce_long_press_top.sv
